[rtl/core/bfp_pkg.sv]
// shared types and constants for the byte fifo embed word packer
package bfp_pkg;

    localparam int FIFO_DEPTH_DEFAULT = 4096;
    localparam int BYTE_W             = 8;
    localparam int SEQ_W              = 6;
    localparam int CNT_FIELD_W        = 2;
    localparam int FILL_W             = 12;
    localparam int WORD_W             = 32;
    localparam int MAX_PAYLOAD        = 3;

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h20;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_TICK
    } bfp_state_t;

endpackage

[rtl/core/bfp_ram.sv]
// single port byte store with registered read data
module bfp_ram
    import bfp_pkg::*;
#(
    parameter int DEPTH  = FIFO_DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(FIFO_DEPTH_DEFAULT)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [BYTE_W-1:0] wdata,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [0:DEPTH-1];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/byte_fifo_embed_word_packer_unit.sv]
// top level: byte fifo with embed word packer
//
// usage: a transaction is accepted on a rising edge with start high and busy low.
// req_type selects a byte write (data_byte is queued) or a service tick that
// removes up to three bytes and packs them into embed_word with a 6-bit
// sequence count and the payload count in byte 0; unused bytes are spaces.
// every transaction yields exactly one result, shown for one cycle with done
// high, carrying write_accepted, embed_word and fill_level.
// a write passes through ST_WRITE and a tick that moves n bytes (0 to 3)
// through ST_TICK before its result is given; busy is high in between and
// drops in the cycle done is shown, so the next transaction may be accepted
// then. a new transaction cannot be accepted before the last has given its
// result; the single port byte store serves one byte read or write per cycle.
// a write to a full fifo (FIFO_DEPTH-1 bytes held) is rejected and drops the
// byte. reset clears pointers, fill count and sequence count; stored bytes
// are not cleared and need no clearing pass. the receiver cannot stall:
// results must be taken in the cycle done is high.
module byte_fifo_embed_word_packer_unit
    import bfp_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              req_type,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              done,
    output logic              write_accepted,
    output logic [WORD_W-1:0] embed_word,
    output logic [FILL_W-1:0] fill_level
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [PTR_W-1:0] MAX_PAY  = PTR_W'(MAX_PAYLOAD);

    bfp_state_t state_reg, state_next;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]       count_reg, count_next;
    logic [SEQ_W-1:0]       seq_reg, seq_next;
    logic [CNT_FIELD_W-1:0] n_reg, n_next;
    logic [CNT_FIELD_W-1:0] idx_reg, idx_next;
    logic [BYTE_W-1:0]      byte_reg, byte_next;
    logic                   done_reg, done_next;
    logic                   acc_reg, acc_next;
    logic [WORD_W-1:0]      word_reg, word_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [BYTE_W-1:0]      pay_reg [0:MAX_PAYLOAD-1];
    logic [BYTE_W-1:0]      pay_next [0:MAX_PAYLOAD-1];

    logic                   ram_we;
    logic [PTR_W-1:0]       ram_addr;
    logic [BYTE_W-1:0]      ram_rdata;
    logic [PTR_W+FILL_W-1:0] fill_ext;

    bfp_ram #(
        .DEPTH  (FIFO_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (byte_reg),
        .rdata (ram_rdata)
    );

    assign fill_ext = {{FILL_W{1'b0}}, count_next};

    always_comb
    begin
        state_next  = state_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        seq_next    = seq_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        byte_next   = byte_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        word_next   = word_reg;
        fill_next   = fill_reg;
        for (int i = 0; i < MAX_PAYLOAD; i++)
        begin
            pay_next[i] = pay_reg[i];
        end
        ram_we   = 1'b0;
        ram_addr = rd_ptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    byte_next = data_byte;
                    idx_next  = '0;
                    if (count_reg > MAX_PAY)
                    begin
                        n_next = CNT_FIELD_W'(MAX_PAYLOAD);
                    end
                    else
                    begin
                        n_next = count_reg[CNT_FIELD_W-1:0];
                    end
                    for (int i = 0; i < MAX_PAYLOAD; i++)
                    begin
                        pay_next[i] = PAD_BYTE;
                    end
                    if (req_type == REQ_TICK)
                    begin
                        state_next = ST_TICK;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                ram_addr = wr_ptr_reg;
                acc_next = 1'b0;
                if (count_reg != LAST_IDX)
                begin
                    ram_we      = 1'b1;
                    acc_next    = 1'b1;
                    count_next  = count_reg + 1'b1;
                    wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
                end
                word_next  = '0;
                fill_next  = fill_ext[FILL_W-1:0];
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_TICK:
            begin
                if (idx_reg != '0)
                begin
                    pay_next[idx_reg - 1'b1] = ram_rdata;
                end
                if (idx_reg != n_reg)
                begin
                    rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
                    idx_next    = idx_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg - {{(PTR_W-CNT_FIELD_W){1'b0}}, n_reg};
                    seq_next   = seq_reg + 1'b1;
                    acc_next   = 1'b0;
                    word_next  = {pay_next[2], pay_next[1], pay_next[0], seq_reg, n_reg};
                    fill_next  = fill_ext[FILL_W-1:0];
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            seq_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            seq_reg    <= seq_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        acc_reg  <= acc_next;
        word_reg <= word_next;
        fill_reg <= fill_next;
        for (int i = 0; i < MAX_PAYLOAD; i++)
        begin
            pay_reg[i] <= pay_next[i];
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign write_accepted = acc_reg;
    assign embed_word     = word_reg;
    assign fill_level     = fill_reg;

endmodule
